[sv/hsd_pkg.sv]
package hsd_pkg;

  // Parser phases.
  localparam logic [2:0] PH_LEN   = 3'd0;
  localparam logic [2:0] PH_COUNT = 3'd1;
  localparam logic [2:0] PH_SYM   = 3'd2;
  localparam logic [2:0] PH_CLEN  = 3'd3;
  localparam logic [2:0] PH_CODE  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;
  localparam logic [2:0] PH_ERR   = 3'd7;

  // Error codes of a result transaction.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_BRANCH = 2'd2;

  // Header field lengths.
  localparam logic [5:0] LEN_BITS   = 6'd32;
  localparam logic [5:0] COUNT_BITS = 6'd8;
  localparam logic [5:0] SYM_BITS   = 6'd8;
  localparam logic [5:0] CLEN_BITS  = 6'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic root_wr;
    logic bit_step;
    logic code_eval;
    logic new_node;
    logic data_eval;
    logic leaf_step;
    logic emit_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr;
    logic code;
    logic data;
    logic stop;
    logic bits_done;
    logic absent;
    logic full;
    logic bad;
    logic leaf;
    logic out_free;
  } sts_t;

endpackage

[sv/hsd_in_if.sv]
interface hsd_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_stream;
  logic [7:0] data_byte;

  modport source (output valid, output start_of_stream, output data_byte, input ready);
  modport sink (input valid, input start_of_stream, input data_byte, output ready);
endinterface

[sv/hsd_out_if.sv]
interface hsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last_symbol;
  logic [1:0] error;

  modport source (output valid, output symbol, output last_symbol, output error, input ready);
  modport sink (input valid, input symbol, input last_symbol, input error, output ready);
endinterface

[sv/huffman_stream_decoder.sv]
// Channel   Direction  Transaction
// in_chan   sink       one compressed byte, optional start-of-stream flag
// out_chan  source     one decoded symbol or one error code
//
// A byte is accepted in S_IDLE and then dispatched bit by bit from S_BIT, with a
// closing S_BIT visit: a header bit is handled in S_BIT alone, a code bit passes S_BIT and
// S_EVAL (and S_NEWN when it allocates a node), a data bit S_BIT, S_EVAL and S_LEAF,
// since each tree step reads the node store once per level. A start-of-stream byte adds
// an S_ROOT step to clear the root; after reset the root is cleared in S_INIT. Reset is synchronous and active low.
// A full output register stalls the walk only when a symbol or error is due.
module huffman_stream_decoder #(
  parameter int NODE_COUNT = 512
) (
  input logic   clk,
  input logic   rst_n,
  hsd_in_if.sink    in_chan,
  hsd_out_if.source out_chan
);
  import hsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_sos   (in_chan.start_of_stream),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hsd_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sos          (in_chan.start_of_stream),
    .in_data_byte    (in_chan.data_byte),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_symbol      (out_chan.symbol),
    .out_last_symbol (out_chan.last_symbol),
    .out_error       (out_chan.error)
  );

endmodule

[sv/hsd_ram.sv]
module hsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/hsd_ctrl.sv]
module hsd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_sos,
  output logic          in_ready,
  input  hsd_pkg::sts_t sts,
  output hsd_pkg::cmd_t cmd
);
  import hsd_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_BIT  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_NEWN = 3'd5;
  localparam logic [2:0] S_LEAF = 3'd6;
  localparam logic [2:0] S_ERR  = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Commands follow from the state, qualified by the input valid and the status.
  always_comb begin
    cmd           = '0;
    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.root_wr   = (state_r == S_INIT) || (state_r == S_ROOT);
    cmd.bit_step  = (state_r == S_BIT);
    cmd.code_eval = (state_r == S_EVAL) && sts.code;
    cmd.data_eval = (state_r == S_EVAL) && sts.data;
    cmd.new_node  = (state_r == S_NEWN);
    cmd.leaf_step = (state_r == S_LEAF);
    cmd.emit_err  = (state_r == S_ERR);
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_sos ? S_ROOT : S_BIT;
        end
      end
      S_ROOT: state_nxt = S_BIT;
      S_BIT: begin
        if (sts.stop || sts.bits_done) begin
          state_nxt = S_IDLE;
        end else if (!sts.hdr) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.code) begin
          if (sts.absent && sts.full) begin
            state_nxt = S_ERR;
          end else if (sts.absent) begin
            state_nxt = S_NEWN;
          end else begin
            state_nxt = S_BIT;
          end
        end else begin
          state_nxt = sts.bad ? S_ERR : S_LEAF;
        end
      end
      S_NEWN: state_nxt = S_BIT;
      S_LEAF: begin
        if (!sts.leaf || sts.out_free) begin
          state_nxt = S_BIT;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          state_nxt = S_BIT;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/hsd_datapath.sv]
module hsd_datapath #(
  parameter int NODE_COUNT = 512,
  localparam int AW = $clog2(NODE_COUNT)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hsd_pkg::cmd_t cmd,
  output hsd_pkg::sts_t sts,
  input  logic          in_sos,
  input  logic [7:0]    in_data_byte,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [7:0]    out_symbol,
  output logic          out_last_symbol,
  output logic [1:0]    out_error
);
  import hsd_pkg::*;

  localparam logic [AW:0] NODE_MAX = (AW+1)'(NODE_COUNT);

  logic [2:0]    phase_r, phase_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [5:0]    fbl_r, fbl_nxt;
  logic [31:0]   orem_r, orem_nxt;
  logic [8:0]    tel_r, tel_nxt;
  logic [7:0]    psym_r, psym_nxt;
  logic [4:0]    cbl_r, cbl_nxt;
  logic [AW:0]   nalloc_r, nalloc_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] child_r, child_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [3:0]    bcnt_r, bcnt_nxt;
  logic          ovld_r, ovld_nxt;
  logic [7:0]    osym_r, osym_nxt;
  logic          olast_r, olast_nxt;
  logic [1:0]    oerr_r, oerr_nxt;

  logic          link_we, byte_we;
  logic [AW-1:0] link_waddr, byte_waddr, rd_addr;
  logic [2*AW-1:0] link_wdata, link_rdata;
  logic [7:0]    byte_wdata, byte_rdata;

  logic          cur_bit;
  logic [AW-1:0] lnk_left, lnk_right, child_sel;
  logic          out_free;
  logic          do_code;
  logic [AW-1:0] code_c;
  logic [31:0]   acc_sh;

  // Node store: child links in one memory, symbol bytes in another.
  hsd_ram #(.WIDTH(2*AW), .DEPTH(NODE_COUNT)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(rd_addr), .rdata(link_rdata)
  );

  hsd_ram #(.WIDTH(8), .DEPTH(NODE_COUNT)) u_bytes (
    .clk(clk), .we(byte_we), .waddr(byte_waddr), .wdata(byte_wdata),
    .raddr(rd_addr), .rdata(byte_rdata)
  );

  assign cur_bit   = byte_r[bcnt_r[2:0]];
  assign lnk_left  = link_rdata[2*AW-1:AW];
  assign lnk_right = link_rdata[AW-1:0];
  assign child_sel = cur_bit ? lnk_right : lnk_left;
  assign out_free  = !ovld_r || out_ready;
  assign acc_sh    = {acc_r[30:0], cur_bit};

  // Status toward the controller.
  always_comb begin
    sts.hdr       = (phase_r <= PH_CLEN);
    sts.code      = (phase_r == PH_CODE);
    sts.data      = (phase_r == PH_DATA);
    sts.stop      = (phase_r == PH_DONE) || (phase_r == PH_ERR);
    sts.bits_done = bcnt_r[3];
    sts.absent    = (child_sel == '0);
    sts.full      = (nalloc_r == NODE_MAX);
    sts.bad       = (child_sel == '0) || ({1'b0, child_sel} >= nalloc_r);
    sts.leaf      = (link_rdata == '0);
    sts.out_free  = out_free;
  end

  // Read address: the current node, the selected child, or the held child.
  always_comb begin
    rd_addr = pos_r;
    if (cmd.code_eval || cmd.data_eval) begin
      rd_addr = child_sel;
    end else if (cmd.leaf_step) begin
      rd_addr = child_r;
    end
  end

  // Main next-state logic of the datapath.
  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    fbl_nxt    = fbl_r;
    orem_nxt   = orem_r;
    tel_nxt    = tel_r;
    psym_nxt   = psym_r;
    cbl_nxt    = cbl_r;
    nalloc_nxt = nalloc_r;
    pos_nxt    = pos_r;
    child_nxt  = child_r;
    byte_nxt   = byte_r;
    bcnt_nxt   = bcnt_r;
    ovld_nxt   = ovld_r && !out_ready;
    osym_nxt   = osym_r;
    olast_nxt  = olast_r;
    oerr_nxt   = oerr_r;
    link_we    = 1'b0;
    link_waddr = pos_r;
    link_wdata = '0;
    byte_we    = 1'b0;
    byte_waddr = child_r;
    byte_wdata = '0;
    do_code    = 1'b0;
    code_c     = child_r;

    // Input transaction: latch the byte, clear the stream on a start marker.
    if (cmd.accept) begin
      byte_nxt = in_data_byte;
      bcnt_nxt = '0;
      if (in_sos) begin
        phase_nxt  = PH_LEN;
        acc_nxt    = '0;
        fbl_nxt    = LEN_BITS;
        orem_nxt   = '0;
        tel_nxt    = '0;
        psym_nxt   = '0;
        cbl_nxt    = '0;
        pos_nxt    = '0;
        nalloc_nxt = (AW+1)'(1);
      end
    end

    // Root node gets no children.
    if (cmd.root_wr) begin
      link_we    = 1'b1;
      link_waddr = '0;
      link_wdata = '0;
    end

    // Header bit: shift into the field and finish it when complete.
    if (cmd.bit_step && sts.hdr && !bcnt_r[3]) begin
      bcnt_nxt = bcnt_r + 4'd1;
      if (fbl_r == 6'd1) begin
        acc_nxt = '0;
        unique case (phase_r)
          PH_LEN: begin
            orem_nxt  = acc_sh;
            phase_nxt = PH_COUNT;
            fbl_nxt   = COUNT_BITS;
          end
          PH_COUNT: begin
            tel_nxt   = {1'b0, acc_sh[7:0]} + 9'd1;
            phase_nxt = PH_SYM;
            fbl_nxt   = SYM_BITS;
          end
          PH_SYM: begin
            psym_nxt  = acc_sh[7:0];
            phase_nxt = PH_CLEN;
            fbl_nxt   = CLEN_BITS;
          end
          default: begin
            cbl_nxt   = {1'b0, acc_sh[3:0]} + 5'd1;
            pos_nxt   = '0;
            phase_nxt = PH_CODE;
          end
        endcase
      end else begin
        acc_nxt = acc_sh;
        fbl_nxt = fbl_r - 6'd1;
      end
    end

    // Code bit: follow an existing branch or allocate a new node.
    if (cmd.code_eval) begin
      if (!sts.absent) begin
        do_code = 1'b1;
        code_c  = child_sel;
      end else if (!sts.full) begin
        link_we    = 1'b1;
        link_waddr = pos_r;
        link_wdata = cur_bit ? {lnk_left, nalloc_r[AW-1:0]}
                             : {nalloc_r[AW-1:0], lnk_right};
        child_nxt  = nalloc_r[AW-1:0];
        nalloc_nxt = nalloc_r + (AW+1)'(1);
      end
    end

    // Fresh node: no children, symbol byte set if the code ends here.
    if (cmd.new_node) begin
      link_we    = 1'b1;
      link_waddr = child_r;
      link_wdata = '0;
      byte_we    = 1'b1;
      byte_waddr = child_r;
      byte_wdata = (cbl_r == 5'd1) ? psym_r : 8'd0;
      do_code    = 1'b1;
      code_c     = child_r;
    end

    // Step along a code; at its end record the symbol and move on.
    if (do_code) begin
      pos_nxt  = code_c;
      cbl_nxt  = cbl_r - 5'd1;
      bcnt_nxt = bcnt_r + 4'd1;
      if (cbl_r == 5'd1) begin
        byte_we    = 1'b1;
        byte_waddr = code_c;
        byte_wdata = psym_r;
        pos_nxt    = '0;
        tel_nxt    = tel_r - 9'd1;
        if (tel_r != 9'd1) begin
          phase_nxt = PH_SYM;
          acc_nxt   = '0;
          fbl_nxt   = SYM_BITS;
        end else begin
          phase_nxt = (orem_r == '0) ? PH_DONE : PH_DATA;
        end
      end
    end

    // Data bit: remember the child whose entry is being read.
    if (cmd.data_eval && !sts.bad) begin
      child_nxt = child_sel;
    end

    // Leaf check: emit the symbol or descend one level.
    if (cmd.leaf_step) begin
      if (!sts.leaf) begin
        pos_nxt  = child_r;
        bcnt_nxt = bcnt_r + 4'd1;
      end else if (out_free) begin
        ovld_nxt  = 1'b1;
        osym_nxt  = byte_rdata;
        olast_nxt = (orem_r == 32'd1);
        oerr_nxt  = ERR_NONE;
        orem_nxt  = orem_r - 32'd1;
        pos_nxt   = '0;
        bcnt_nxt  = bcnt_r + 4'd1;
        if (orem_r == 32'd1) begin
          phase_nxt = PH_DONE;
        end
      end
    end

    // Error transaction, then ignore input until the next stream.
    if (cmd.emit_err && out_free) begin
      ovld_nxt  = 1'b1;
      osym_nxt  = 8'd0;
      olast_nxt = 1'b0;
      oerr_nxt  = (phase_r == PH_CODE) ? ERR_FULL : ERR_BRANCH;
      phase_nxt = PH_ERR;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      acc_r    <= '0;
      fbl_r    <= LEN_BITS;
      orem_r   <= '0;
      tel_r    <= '0;
      psym_r   <= '0;
      cbl_r    <= '0;
      nalloc_r <= (AW+1)'(1);
      pos_r    <= '0;
      bcnt_r   <= '0;
      ovld_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      fbl_r    <= fbl_nxt;
      orem_r   <= orem_nxt;
      tel_r    <= tel_nxt;
      psym_r   <= psym_nxt;
      cbl_r    <= cbl_nxt;
      nalloc_r <= nalloc_nxt;
      pos_r    <= pos_nxt;
      bcnt_r   <= bcnt_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    child_r <= child_nxt;
    byte_r  <= byte_nxt;
    osym_r  <= osym_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign out_valid       = ovld_r;
  assign out_symbol      = osym_r;
  assign out_last_symbol = olast_r;
  assign out_error       = oerr_r;

  // The allocation count stays between the root alone and a full store.
  a_nalloc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nalloc_r >= (AW+1)'(1)) && (nalloc_r <= NODE_MAX))
    else $error("node allocation count out of range");

  // The walk position always names an allocated node.
  a_pos_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} < nalloc_r)
    else $error("walk position beyond allocated nodes");

  // An error result carries no symbol and no last flag.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && (oerr_r != ERR_NONE)) |-> ((osym_r == 8'd0) && !olast_r))
    else $error("error result with symbol data");

  // A result is only loaded while the parser is in a tree phase.
  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_nxt && !ovld_r) |-> ((phase_r == PH_CODE) || (phase_r == PH_DATA)))
    else $error("result produced outside code or data phase");

endmodule

[sim/huffman_stream_decoder_tb.sv]
`timescale 1ns / 100ps

module huffman_stream_decoder_tb;
  import hsd_pkg::*;

  localparam int NODES       = 512;
  localparam int STALL_MAX   = 6000;
  localparam int TAIL_WAIT   = 60;
  localparam int TOTAL_ITEMS = 210;

  typedef struct packed {
    logic       sos;
    logic [7:0] data;
    logic       drain;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic [1:0] err;
  } decode_result_t;

  logic clk;
  logic rst_n;

  hsd_in_if  in_chan ();
  hsd_out_if out_chan ();

  huffman_stream_decoder #(.NODE_COUNT(NODES)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  byte_item_t     byte_queue[$];
  decode_result_t expected_symbols[$];
  int             fail_count;
  int             bytes_sent;
  int             total_bytes;
  int             stream_count;
  int             symbols_seen;
  int             errors_seen;
  int             idle_cycles;
  int             drain_hold;

  // Decoder state mirrored for prediction.
  logic [2:0]  dec_phase;
  logic [31:0] dec_acc;
  int          dec_field_left;
  logic [31:0] dec_remaining;
  int          dec_entries;
  logic [7:0]  dec_symbol;
  int          dec_code_left;
  int          dec_walk;
  int          dec_alloc;
  int          node_left[NODES];
  int          node_right[NODES];
  logic [7:0]  node_byte[NODES];

  task automatic clear_decoder();
    dec_phase      = PH_LEN;
    dec_acc        = '0;
    dec_field_left = 32;
    dec_remaining  = '0;
    dec_entries    = 0;
    dec_symbol     = '0;
    dec_code_left  = 0;
    dec_walk       = 0;
    dec_alloc      = 1;
    node_left[0]   = 0;
    node_right[0]  = 0;
    node_byte[0]   = '0;
  endtask

  task automatic push_result(logic [7:0] sym, logic last, logic [1:0] err);
    decode_result_t r;
    r.sym  = sym;
    r.last = last;
    r.err  = err;
    expected_symbols.insert(expected_symbols.size(), r);
  endtask

  task automatic next_field(logic [2:0] ph, int bits);
    dec_phase      = ph;
    dec_acc        = '0;
    dec_field_left = bits;
  endtask

  // One compressed bit through the header parser or the tree walk.
  task automatic decode_bit(logic b);
    int child;
    if (dec_phase <= PH_CLEN) begin
      dec_acc = {dec_acc[30:0], b};
      if (dec_field_left > 0) dec_field_left--;
      if (dec_field_left == 0) begin
        case (dec_phase)
          PH_LEN: begin
            dec_remaining = dec_acc;
            next_field(PH_COUNT, 8);
          end
          PH_COUNT: begin
            dec_entries = int'(dec_acc[7:0]) + 1;
            next_field(PH_SYM, 8);
          end
          PH_SYM: begin
            dec_symbol = dec_acc[7:0];
            next_field(PH_CLEN, 4);
          end
          default: begin
            dec_code_left = int'(dec_acc[3:0]) + 1;
            dec_walk      = 0;
            dec_phase     = PH_CODE;
          end
        endcase
      end
    end else if (dec_phase == PH_CODE) begin
      child = b ? node_right[dec_walk] : node_left[dec_walk];
      if (child == 0) begin
        if (dec_alloc >= NODES) begin
          push_result('0, 1'b0, ERR_FULL);
          dec_phase = PH_ERR;
          return;
        end
        child             = dec_alloc;
        dec_alloc         = dec_alloc + 1;
        node_left[child]  = 0;
        node_right[child] = 0;
        node_byte[child]  = '0;
        if (b) node_right[dec_walk] = child;
        else   node_left[dec_walk]  = child;
      end
      dec_walk = child;
      if (dec_code_left > 0) dec_code_left--;
      if (dec_code_left == 0) begin
        node_byte[child] = dec_symbol;
        dec_walk         = 0;
        if (dec_entries > 0) dec_entries--;
        if (dec_entries != 0) next_field(PH_SYM, 8);
        else dec_phase = (dec_remaining == 0) ? PH_DONE : PH_DATA;
      end
    end else if (dec_phase == PH_DATA) begin
      child = b ? node_right[dec_walk] : node_left[dec_walk];
      if (child == 0 || child >= dec_alloc) begin
        push_result('0, 1'b0, ERR_BRANCH);
        dec_phase = PH_ERR;
      end else if (node_left[child] == 0 && node_right[child] == 0) begin
        dec_remaining--;
        dec_walk = 0;
        push_result(node_byte[child], dec_remaining == 0, ERR_NONE);
        if (dec_remaining == 0) dec_phase = PH_DONE;
      end else begin
        dec_walk = child;
      end
    end
  endtask

  task automatic decode_byte(logic sos, logic [7:0] data);
    if (sos) clear_decoder();
    for (int i = 0; i < 8; i++) begin
      if (dec_phase == PH_DONE || dec_phase == PH_ERR) break;
      decode_bit(data[i]);
    end
  endtask

  // Stream construction: header and data bits, packed LSB first into bytes.
  logic        bitq[$];
  logic [15:0] code_val[256];
  int          code_len[256];
  logic [7:0]  sym_val[256];

  task automatic put_field(logic [31:0] v, int w);
    for (int i = w - 1; i >= 0; i--) bitq.insert(bitq.size(), v[i]);
  endtask

  task automatic flush_stream(logic drain);
    byte_item_t it;
    bit first;
    first = 1'b1;
    while (bitq.size() % 8 != 0) bitq.insert(bitq.size(), 1'($urandom_range(0, 1)));
    while (bitq.size() > 0) begin
      for (int i = 0; i < 8; i++) it.data[i] = bitq.pop_front();
      it.sos   = first;
      it.drain = first & drain;
      first    = 1'b0;
      byte_queue.insert(byte_queue.size(), it);
    end
    stream_count++;
  endtask

  // kind 0: unary code, 1: balanced code of depth clog2(n), 2: random codes.
  // After the header, 'symbols' coded symbols and then 'junk' random bits.
  task automatic make_stream(int kind, int n, logic [31:0] hdr_len, int symbols, int junk,
                             logic drain);
    int k;
    for (int i = 0; i < n; i++) begin
      sym_val[i] = 8'($urandom_range(0, 255));
      if (kind == 0) begin
        code_len[i] = (n == 1) ? 1 : ((i < n - 1) ? i + 1 : n - 1);
        code_val[i] = (i < n - 1) ? ((16'(1) << code_len[i]) - 16'd2) :
                                    ((16'(1) << code_len[i]) - 16'd1);
        if (n == 1) code_val[i] = '0;
      end else if (kind == 1) begin
        code_len[i] = $clog2(n);
        code_val[i] = 16'(i);
      end else begin
        code_len[i] = $urandom_range(1, 16);
        code_val[i] = 16'($urandom);
      end
    end
    put_field(hdr_len, 32);
    put_field(32'(n - 1), 8);
    for (int i = 0; i < n; i++) begin
      put_field(32'(sym_val[i]), 8);
      put_field(32'(code_len[i] - 1), 4);
      put_field(32'(code_val[i]), code_len[i]);
    end
    for (int s = 0; s < symbols; s++) begin
      k = $urandom_range(0, n - 1);
      put_field(32'(code_val[k]), code_len[k]);
    end
    for (int j = 0; j < junk; j++) bitq.insert(bitq.size(), 1'($urandom_range(0, 1)));
    flush_stream(drain);
  endtask

  task automatic noise_bytes(int cnt);
    byte_item_t it;
    for (int i = 0; i < cnt; i++) begin
      it.sos   = ($urandom_range(0, 3) == 0);
      it.data  = 8'($urandom);
      it.drain = 1'b0;
      byte_queue.insert(byte_queue.size(), it);
    end
  endtask

  // Stimulus: directed streams first, then random ones.
  initial begin
    int n;
    int kind;
    int r;
    fail_count   = 0;
    stream_count = 0;
    // Single-symbol tree, zero length and full length extremes.
    make_stream(0, 1, 32'd3, 3, 0, 1'b0);
    make_stream(1, 2, 32'd0, 0, 16, 1'b0);
    make_stream(0, 1, 32'hFFFF_FFFF, 2, 0, 1'b0);
    // Single code "0", then a data bit of 1 takes a missing branch.
    put_field(32'd4, 32); put_field(32'd0, 8); put_field(32'hA5, 8);
    put_field(32'd0, 4); put_field(32'd0, 1); put_field(32'b001, 3);
    flush_stream(1'b0);
    // A balanced table of depth 4, and a 16-bit unary code.
    make_stream(1, 16, 32'd8, 8, 0, 1'b1);
    make_stream(0, 17, 32'd6, 6, 0, 1'b0);
    // Long random codes that share prefixes.
    make_stream(2, 8, 32'd1, 0, 0, 1'b0);
    // Codes ending on inner nodes and passing through leaves.
    make_stream(2, 6, 32'd5, 0, 40, 1'b0);
    while (byte_queue.size() < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        kind = $urandom_range(0, 1);
        n    = (kind == 0) ? $urandom_range(1, 9) : (1 << $urandom_range(1, 4));
        r    = $urandom_range(1, 12);
        make_stream(kind, n, ($urandom_range(0, 9) == 0) ? 32'd0 : 32'(r), r,
                    $urandom_range(0, 10), (stream_count % 12 == 0));
      end else if (r < 85) begin
        n = $urandom_range(1, 8);
        make_stream(2, n, 32'($urandom_range(1, 10)), 0, $urandom_range(8, 40), 1'b0);
      end else begin
        noise_bytes($urandom_range(1, 6));
      end
    end
    total_bytes = byte_queue.size();
  end

  // Reset and input defaults.
  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.start_of_stream = 1'b0;
    in_chan.data_byte = '0;
    out_chan.ready    = 1'b0;
    clear_decoder();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int idle_phase();
    if (bytes_sent < total_bytes / 3) return 0;
    if (bytes_sent < (2 * total_bytes) / 3) return 1;
    return 2;
  endfunction

  // Driver: predicts each accepted byte and presents the next pending one.
  initial begin
    bytes_sent = 0;
    drain_hold = 0;
  end

  always @(posedge clk) begin
    int pct;
    bit go;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        decode_byte(in_chan.start_of_stream, in_chan.data_byte);
        void'(byte_queue.pop_front());
        bytes_sent++;
      end
      pct = (idle_phase() == 0) ? 25 : ((idle_phase() == 1) ? 49 : 0);
      go  = (byte_queue.size() > 0) && ($urandom_range(0, 99) >= pct);
      if (in_chan.valid && !in_chan.ready) go = 1'b1;
      // Hold a marked stream back until the decoder has fully drained.
      if (go && byte_queue[0].drain && !(in_chan.valid && !in_chan.ready)) begin
        if (expected_symbols.size() != 0) drain_hold = 0;
        else drain_hold++;
        if (drain_hold < TAIL_WAIT) go = 1'b0;
        else byte_queue[0].drain = 1'b0;
      end
      if (in_chan.valid && in_chan.ready && !go) begin
        in_chan.valid <= 1'b0;
      end else if (go) begin
        in_chan.valid           <= 1'b1;
        in_chan.start_of_stream <= byte_queue[0].sos;
        in_chan.data_byte       <= byte_queue[0].data;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Monitor: receiver stalls, result checks and the watchdog.
  always @(posedge clk) begin
    decode_result_t exp_r;
    int pct;
    if (rst_n) begin
      pct = (idle_phase() == 0) ? 49 : ((idle_phase() == 1) ? 25 : 0);
      out_chan.ready <= ($urandom_range(0, 99) >= pct);
      if (out_chan.valid && out_chan.ready) begin
        if (expected_symbols.size() == 0) begin
          $error("unexpected result: symbol %0h last %0b error %0d",
                 out_chan.symbol, out_chan.last_symbol, out_chan.error);
          fail_count++;
        end else begin
          exp_r = expected_symbols.pop_front();
          if (out_chan.error != ERR_NONE) errors_seen++;
          else symbols_seen++;
          if (out_chan.symbol !== exp_r.sym) begin
            $error("symbol: expected %0h, actual %0h", exp_r.sym, out_chan.symbol);
            fail_count++;
          end
          if (out_chan.last_symbol !== exp_r.last) begin
            $error("last_symbol: expected %0b, actual %0b", exp_r.last,
                   out_chan.last_symbol);
            fail_count++;
          end
          if (out_chan.error !== exp_r.err) begin
            $error("error: expected %0d, actual %0d", exp_r.err, out_chan.error);
            fail_count++;
          end
        end
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("Timeout: no transaction for %0d cycles", STALL_MAX);
        $display("Test completed with failures");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // End of run.
  initial begin
    symbols_seen = 0;
    errors_seen  = 0;
    wait (rst_n === 1'b1);
    wait (total_bytes > 0 && bytes_sent == total_bytes);
    wait (expected_symbols.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (expected_symbols.size() != 0) begin
      $error("%0d expected results never arrived", expected_symbols.size());
      fail_count++;
    end
    $display("Sent %0d bytes in %0d streams; checked %0d symbols and %0d error results.",
             bytes_sent, stream_count, symbols_seen, errors_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[huffman_stream_decoder.f]
sv/hsd_pkg.sv
sv/hsd_in_if.sv
sv/hsd_out_if.sv
sv/hsd_ram.sv
sv/hsd_ctrl.sv
sv/hsd_datapath.sv
sv/huffman_stream_decoder.sv
sim/huffman_stream_decoder_tb.sv
